/* hw/rtl/hhd_pkg.sv */
// Package for the HPACK Huffman decoder: payload types, result kinds,
// trie and code table constants, and the code length table.
// No dependencies.
package hhd_pkg;

  localparam int unsigned SYMBOLS      = 257;
  localparam int unsigned SYM_W        = $clog2(SYMBOLS);
  localparam int unsigned EOS_SYM      = 256;
  localparam int unsigned CODE_W       = 30;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned MAX_CODE_LEN = 30;
  localparam int unsigned CROM_W       = CODE_W + LEN_W;

  localparam int unsigned MAX_NODES  = 32;
  localparam int unsigned NODE_W     = $clog2(MAX_NODES);
  localparam int unsigned TRIE_DEPTH = MAX_NODES * 256;
  localparam int unsigned TRIE_AW    = $clog2(TRIE_DEPTH);
  localparam int unsigned ENT_W      = 16;
  localparam int unsigned TERM_BIT   = 15;

  typedef enum logic [1:0] {
    KIND_SYM = 2'd0,
    KIND_OK  = 2'd1,
    KIND_EOS = 2'd2,
    KIND_PAD = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [7:0] symbol;
    kind_e      kind;
    logic       last;
  } out_req_t;

  localparam logic [LEN_W-1:0] CODE_LEN [SYMBOLS] = '{
    5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
    5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
    5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
    5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
    5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
    5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
    5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
    5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
    5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
    5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
    5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
    5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
    5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
    5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
    5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
    5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
    5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
    5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
    5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
    5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
    5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
    5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
    5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
    5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
    5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
    5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
    5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
    5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26,
    5'd30
  };

endpackage

/* hw/rtl/hhd_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module hhd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/hpack_huffman_decoder.sv */
// HPACK Huffman decoder. Reset is asynchronous active low and restarts the trie build:
// trie RAM clear, code table sweep per code length, code insertion; no request is taken.
// Per byte: accept, then S_LOOK and S_EVAL per trie lookup (one RAM read port), then exit;
// a final byte ends with flush lookups and a status result instead.
// Results leave through an output register; a stalled output holds the decoder.
// Depends on hhd_pkg and hhd_ram.
module hpack_huffman_decoder import hhd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_CODE  = 4'd1;
  localparam logic [3:0] S_SYM   = 4'd2;
  localparam logic [3:0] S_SYMW  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_WALKR = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_IDLE  = 4'd7;
  localparam logic [3:0] S_LOOK  = 4'd8;
  localparam logic [3:0] S_EVAL  = 4'd9;
  localparam logic [3:0] S_FLOOK = 4'd10;
  localparam logic [3:0] S_FEVAL = 4'd11;
  localparam logic [3:0] S_STAT  = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [TRIE_AW-1:0] clr_q, clr_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CODE_W-1:0]  next_q, next_d;
  logic [NODE_W:0]    node_cnt_q, node_cnt_d;
  logic [NODE_W-1:0]  cur_q, cur_d;
  logic [LEN_W-1:0]   rlen_q, rlen_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [7:0]         idx_q, idx_d;
  logic [6:0]         fill_q, fill_d;
  logic [15:0]        buf_q, buf_d;
  logic [3:0]         bits_q, bits_d;
  logic [NODE_W-1:0]  pos_q, pos_d;
  logic               err_q, err_d;
  logic               fin_q, fin_d;
  logic               out_valid_q;
  out_req_t           out_q;

  logic               t_we, t_re;
  logic [TRIE_AW-1:0] t_waddr, t_raddr;
  logic [ENT_W-1:0]   t_wdata, t_rdata;
  logic               c_we, c_re;
  logic [SYM_W-1:0]   c_waddr, c_raddr;
  logic [CROM_W-1:0]  c_wdata, c_rdata;

  logic               emit;
  out_req_t           emit_data;
  logic               slot_free, next_sym, hit;
  logic [CODE_W-1:0]  next_inc;
  logic               e_term, e_eos;
  logic [3:0]         e_len;
  logic [LEN_W-1:0]   walk_rem;
  logic [7:0]         walk_idx, fill_start, look_idx, flush_idx, pad_mask;
  logic [2:0]         fill_shift;
  logic [6:0]         fill_last;
  logic               pad_ok;

  hhd_ram #(.WIDTH(ENT_W), .DEPTH(TRIE_DEPTH)) u_trie_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  hhd_ram #(.WIDTH(CROM_W), .DEPTH(SYMBOLS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign e_term     = t_rdata[TERM_BIT];
  assign e_len      = t_rdata[12:9];
  assign e_eos      = t_rdata[SYM_W-1:0] == SYM_W'(EOS_SYM);
  assign hit        = CODE_LEN[sym_q] == len_q;
  assign next_inc   = next_q + CODE_W'(hit);
  assign walk_rem   = rlen_q - LEN_W'(8);
  assign walk_idx   = 8'(code_q >> walk_rem);
  assign fill_shift = 3'(4'd8 - 4'(rlen_q));
  assign fill_start = 8'(code_q << fill_shift);
  assign fill_last  = 7'((8'd1 << fill_shift) - 8'd1);
  assign look_idx   = 8'(buf_q >> (bits_q - 4'd8));
  assign flush_idx  = 8'(buf_q << (4'd8 - bits_q));
  assign pad_mask   = 8'((9'd1 << bits_q[2:0]) - 9'd1);
  assign pad_ok     = (buf_q[7:0] & pad_mask) == pad_mask;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    sym_d      = sym_q;
    len_d      = len_q;
    next_d     = next_q;
    node_cnt_d = node_cnt_q;
    cur_d      = cur_q;
    rlen_d     = rlen_q;
    code_d     = code_q;
    idx_d      = idx_q;
    fill_d     = fill_q;
    buf_d      = buf_q;
    bits_d     = bits_q;
    pos_d      = pos_q;
    err_d      = err_q;
    fin_d      = fin_q;
    t_we       = 1'b0;
    t_waddr    = '0;
    t_wdata    = '0;
    t_re       = 1'b0;
    t_raddr    = '0;
    c_we       = 1'b0;
    c_waddr    = sym_q;
    c_wdata    = {len_q, next_q};
    c_re       = 1'b0;
    c_raddr    = sym_q;
    in_stall_o = 1'b1;
    emit       = 1'b0;
    emit_data  = '{symbol: t_rdata[7:0], kind: KIND_SYM, last: 1'b0};
    next_sym   = 1'b0;

    unique case (state_q)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_q;
        clr_d   = clr_q + TRIE_AW'(1);
        if (clr_q == TRIE_AW'(TRIE_DEPTH - 1)) begin
          state_d = S_CODE;
        end
      end
      // canonical code assignment: one symbol per cycle, one length per sweep
      S_CODE: begin
        c_we = hit;
        if (sym_q == SYM_W'(SYMBOLS - 1)) begin
          sym_d  = '0;
          len_d  = len_q + LEN_W'(1);
          next_d = next_inc << 1;
          if (len_q == LEN_W'(MAX_CODE_LEN)) begin
            state_d = S_SYM;
          end
        end else begin
          sym_d  = sym_q + SYM_W'(1);
          next_d = next_inc;
        end
      end
      S_SYM: begin
        c_re    = 1'b1;
        state_d = S_SYMW;
      end
      S_SYMW: begin
        code_d  = c_rdata[CODE_W-1:0];
        rlen_d  = c_rdata[CODE_W +: LEN_W];
        cur_d   = '0;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (rlen_q > LEN_W'(8)) begin
          rlen_d  = walk_rem;
          idx_d   = walk_idx;
          t_re    = 1'b1;
          t_raddr = {cur_q, walk_idx};
          state_d = S_WALKR;
        end else begin
          fill_d  = '0;
          state_d = S_FILL;
        end
      end
      S_WALKR: begin
        if (e_term) begin
          next_sym = 1'b1;
        end else if (t_rdata == '0) begin
          // allocate a new node, or drop the code when the trie is full
          if (node_cnt_q >= (NODE_W + 1)'(MAX_NODES)) begin
            next_sym = 1'b1;
          end else begin
            t_we       = 1'b1;
            t_waddr    = {cur_q, idx_q};
            t_wdata    = ENT_W'(node_cnt_q);
            cur_d      = node_cnt_q[NODE_W-1:0];
            node_cnt_d = node_cnt_q + (NODE_W + 1)'(1);
            state_d    = S_WALK;
          end
        end else begin
          cur_d   = t_rdata[NODE_W-1:0];
          state_d = S_WALK;
        end
      end
      S_FILL: begin
        t_we    = 1'b1;
        t_waddr = {cur_q, fill_start + 8'(fill_q)};
        t_wdata = {1'b1, 2'b00, 4'(rlen_q), sym_q};
        fill_d  = fill_q + 7'd1;
        if (fill_q == fill_last) begin
          next_sym = 1'b1;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          fin_d = in_i.end_of_string;
          if (!err_q) begin
            buf_d   = {buf_q[7:0], in_i.in_byte};
            bits_d  = bits_q + 4'd8;
            state_d = S_LOOK;
          end else if (in_i.end_of_string) begin
            state_d = S_STAT;
          end
        end
      end
      S_LOOK: begin
        if (bits_q >= 4'd8) begin
          t_re    = 1'b1;
          t_raddr = {pos_q, look_idx};
          state_d = S_EVAL;
        end else if (fin_q) begin
          state_d = S_FLOOK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EVAL: begin
        if (e_term) begin
          if (e_eos) begin
            err_d   = 1'b1;
            buf_d   = '0;
            bits_d  = '0;
            pos_d   = '0;
            state_d = fin_q ? S_STAT : S_IDLE;
          end else if (slot_free) begin
            emit    = 1'b1;
            bits_d  = bits_q - e_len;
            pos_d   = '0;
            state_d = S_LOOK;
          end
        end else begin
          bits_d  = bits_q - 4'd8;
          pos_d   = (ENT_W'(node_cnt_q) > t_rdata) ? t_rdata[NODE_W-1:0] : '0;
          state_d = S_LOOK;
        end
      end
      S_FLOOK: begin
        if (bits_q != 4'd0) begin
          t_re    = 1'b1;
          t_raddr = {pos_q, flush_idx};
          state_d = S_FEVAL;
        end else begin
          state_d = S_STAT;
        end
      end
      // flush: only a code that fits in the leftover bits counts
      S_FEVAL: begin
        if (e_term && (e_len <= bits_q)) begin
          if (e_eos) begin
            err_d   = 1'b1;
            buf_d   = '0;
            bits_d  = '0;
            pos_d   = '0;
            state_d = S_STAT;
          end else if (slot_free) begin
            emit    = 1'b1;
            bits_d  = bits_q - e_len;
            pos_d   = '0;
            state_d = S_FLOOK;
          end
        end else begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_data.symbol = '0;
          emit_data.last   = 1'b1;
          if (err_q) begin
            emit_data.kind = KIND_EOS;
          end else if ((pos_q != '0) || !pad_ok) begin
            emit_data.kind = KIND_PAD;
          end else begin
            emit_data.kind = KIND_OK;
          end
          buf_d   = '0;
          bits_d  = '0;
          pos_d   = '0;
          err_d   = 1'b0;
          fin_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase

    if (next_sym) begin
      if (sym_q == SYM_W'(SYMBOLS - 1)) begin
        state_d = S_IDLE;
      end else begin
        sym_d   = sym_q + SYM_W'(1);
        state_d = S_SYM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      sym_q       <= '0;
      len_q       <= LEN_W'(1);
      next_q      <= '0;
      node_cnt_q  <= (NODE_W + 1)'(1);
      cur_q       <= '0;
      rlen_q      <= '0;
      code_q      <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      buf_q       <= '0;
      bits_q      <= '0;
      pos_q       <= '0;
      err_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      sym_q      <= sym_d;
      len_q      <= len_d;
      next_q     <= next_d;
      node_cnt_q <= node_cnt_d;
      cur_q      <= cur_d;
      rlen_q     <= rlen_d;
      code_q     <= code_d;
      idx_q      <= idx_d;
      fill_q     <= fill_d;
      buf_q      <= buf_d;
      bits_q     <= bits_d;
      pos_q      <= pos_d;
      err_q      <= err_d;
      fin_q      <= fin_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_trie_write_build_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_we |-> (state_q == S_CLR || state_q == S_WALKR || state_q == S_FILL))
    else $error("trie written outside build");

  a_idle_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> bits_q < 4'd8)
    else $error("eight or more bits left between bytes");

  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.last == (out_o.kind != KIND_SYM)))
    else $error("last flag does not match result kind");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_cnt_q <= (NODE_W + 1)'(MAX_NODES))
    else $error("node count beyond trie size");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (pos_q == '0 && bits_q == '0))
    else $error("bits kept after EOS error");

endmodule
